// ----- hdl/qbdp_pkg.sv -----
// Shared types and constants for the quantized block dot product.
`default_nettype none
package qbdp_pkg;

  // One classified item as it sits in the queue, activations excluded.
  typedef struct packed {
    logic signed [7:0] w_lo;     // weight for act_low
    logic signed [7:0] w_hi;     // weight for act_high (zero in eight-bit mode)
    logic [15:0]       scale;    // raw half-precision block scale
    logic              blk_end;  // item closes a block (block or row end)
    logic              row_end;  // item closes the row
  } item_ctrl_t;

  localparam logic       FMT_Q4 = 1'b0;
  localparam logic       FMT_Q8 = 1'b1;

  localparam logic [7:0] NIBBLE_MASK = 8'h0F;
  localparam logic [7:0] NIBBLE_BIAS = 8'd8;
  localparam int         NIBBLE_BITS = 4;

  localparam int         HALF_MANT_BITS = 10;
  localparam logic [4:0] EXP_INF        = 5'd31;
  localparam logic [4:0] EXP_SUBNORMAL  = 5'd0;
  localparam logic [4:0] EXP_PIVOT      = 5'd17;

endpackage
`default_nettype wire

// ----- hdl/qbdp_front.sv -----
// Front end: format register, input handshake and weight decode into queue entries.
`default_nettype none
module qbdp_front
  import qbdp_pkg::*;
#(
  parameter int ACT_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write_en,
  input  wire logic                 cfg_write_data,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire logic [7:0]           weight_byte,
  input  wire logic [ACT_BITS-1:0]  act_low,
  input  wire logic [ACT_BITS-1:0]  act_high,
  input  wire logic [15:0]          scale_bits,
  input  wire logic                 end_of_block,
  input  wire logic                 end_of_row,
  output      logic                 push_valid,
  input  wire logic                 push_ready,
  output      logic [2*ACT_BITS+$bits(item_ctrl_t)-1:0] push_data
);

  logic       quant_format;
  logic [7:0] lo_nib;
  logic [7:0] hi_nib;
  item_ctrl_t ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      quant_format <= FMT_Q4;
    end else if (cfg_write_en) begin
      quant_format <= cfg_write_data;
    end
  end

  assign lo_nib = weight_byte & NIBBLE_MASK;
  assign hi_nib = weight_byte >> NIBBLE_BITS;

  always_comb begin
    ctrl.scale   = scale_bits;
    ctrl.blk_end = end_of_block | end_of_row;
    ctrl.row_end = end_of_row;
    case (quant_format)
      FMT_Q4: begin
        ctrl.w_lo = lo_nib - NIBBLE_BIAS;
        ctrl.w_hi = hi_nib - NIBBLE_BIAS;
      end
      FMT_Q8: begin
        ctrl.w_lo = weight_byte;
        ctrl.w_hi = '0;
      end
      default: begin
        ctrl.w_lo = '0;
        ctrl.w_hi = '0;
      end
    endcase
  end

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign push_data  = {act_high, act_low, ctrl};

endmodule
`default_nettype wire

// ----- hdl/qbdp_queue.sv -----
// Short register queue between the front end and the accumulate engine.
`default_nettype none
module qbdp_queue #(
  parameter int WIDTH = 66,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output      logic             push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output      logic             pop_valid,
  input  wire logic             pop_ready,
  output      logic [WIDTH-1:0] pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL     = CW'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  assign push_ready = (count != FULL);
  assign pop_valid  = (count != '0);
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL)
    else $error("queue count beyond depth");
  a_push_only: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + CW'(1))
    else $error("queue count missed a push");
  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> count == $past(count) - CW'(1))
    else $error("queue count missed a pop");
`endif

endmodule
`default_nettype wire

// ----- hdl/qbdp_back.sv -----
// Back end: block multiply-accumulate, fp16 scaling, row accumulation and result register.
`default_nettype none
module qbdp_back
  import qbdp_pkg::*;
#(
  parameter int ACT_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 pop_valid,
  output      logic                 pop_ready,
  input  wire logic [2*ACT_BITS+$bits(item_ctrl_t)-1:0] pop_data,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      logic signed [63:0]   dot_value,
  output      logic                 saturated,
  output      logic                 bad_scale
);

  localparam int BSUM_BITS = ACT_BITS + 13;
  localparam int PPROD_BITS = ACT_BITS + 8;
  localparam int TERM_BITS = ACT_BITS + 9;
  localparam int SUM_BITS = BSUM_BITS + 1;
  localparam int PROD_BITS = BSUM_BITS + HALF_MANT_BITS + 1;

  localparam logic [1:0] S_ACC   = 2'd0;
  localparam logic [1:0] S_MUL   = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_ADD   = 2'd3;

  localparam logic signed [BSUM_BITS-1:0] BSUM_MAX = {1'b0, {(BSUM_BITS-1){1'b1}}};
  localparam logic signed [BSUM_BITS-1:0] BSUM_MIN = {1'b1, {(BSUM_BITS-1){1'b0}}};
  localparam logic signed [63:0] ROW_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] ROW_MIN = {1'b1, {63{1'b0}}};

  logic [1:0] state;

  // control and sums
  logic signed [BSUM_BITS-1:0] bsum;
  logic signed [63:0]          row_sum;
  logic                        clip_seen;
  logic                        bad_seen;

  // block-end work registers
  logic [15:0]                 scale_q;
  logic                        row_end_q;
  logic [PROD_BITS-1:0]        prod_q;
  logic                        neg_q;
  logic [4:0]                  exp_q;
  logic signed [63:0]          contrib_q;

  // head item
  item_ctrl_t                  ctrl;
  logic signed [ACT_BITS-1:0]  a_lo;
  logic signed [ACT_BITS-1:0]  a_hi;
  logic signed [7:0]           w_lo;
  logic signed [7:0]           w_hi;
  logic signed [PPROD_BITS-1:0] p_lo;
  logic signed [PPROD_BITS-1:0] p_hi;
  logic signed [TERM_BITS-1:0] term;
  logic signed [SUM_BITS-1:0]  bsum_wide;
  logic                        bsum_ovf;
  logic signed [BSUM_BITS-1:0] bsum_next;

  // scaling
  logic [4:0]                  exp_raw;
  logic [10:0]                 mant;
  logic [BSUM_BITS-1:0]        mag;
  logic [63:0]                 prod_wide;
  logic [4:0]                  rshift;
  logic [63:0]                 scaled;

  // row add
  logic signed [64:0]          row_wide;
  logic                        row_ovf;
  logic signed [63:0]          row_next;
  logic                        out_free;
  logic                        publish;

  assign {a_hi, a_lo, ctrl} = pop_data;
  assign w_lo = ctrl.w_lo;
  assign w_hi = ctrl.w_hi;
  assign pop_ready = (state == S_ACC);
  assign publish = (state == S_ADD) && row_end_q && out_free;

  always_comb begin
    p_lo      = w_lo * a_lo;
    p_hi      = w_hi * a_hi;
    term      = TERM_BITS'(p_lo) + TERM_BITS'(p_hi);
    bsum_wide = SUM_BITS'(bsum) + SUM_BITS'(term);
    bsum_ovf  = bsum_wide[SUM_BITS-1] != bsum_wide[SUM_BITS-2];
    if (!bsum_ovf) begin
      bsum_next = bsum_wide[BSUM_BITS-1:0];
    end else if (bsum_wide[SUM_BITS-1]) begin
      bsum_next = BSUM_MIN;
    end else begin
      bsum_next = BSUM_MAX;
    end
  end

  // scale significand; inf/NaN forces a zero contribution
  always_comb begin
    exp_raw = scale_q[14:10];
    mant    = {exp_raw != EXP_SUBNORMAL, scale_q[9:0]};
    if (exp_raw == EXP_INF) begin
      mant = '0;
    end
    mag = bsum[BSUM_BITS-1] ? (~bsum + BSUM_BITS'(1)) : bsum;
  end

  // shift by exponent - 17; right shifts round the magnitude half up
  always_comb begin
    prod_wide = 64'(prod_q);
    rshift    = EXP_PIVOT - exp_q;
    if (exp_q >= EXP_PIVOT) begin
      scaled = prod_wide << (exp_q - EXP_PIVOT);
    end else begin
      scaled = (prod_wide + (64'd1 << (rshift - 5'd1))) >> rshift;
    end
  end

  always_comb begin
    row_wide = {row_sum[63], row_sum} + {contrib_q[63], contrib_q};
    row_ovf  = row_wide[64] != row_wide[63];
    if (!row_ovf) begin
      row_next = row_wide[63:0];
    end else if (row_wide[64]) begin
      row_next = ROW_MIN;
    end else begin
      row_next = ROW_MAX;
    end
    out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_ACC;
      bsum      <= '0;
      row_sum   <= '0;
      clip_seen <= 1'b0;
      bad_seen  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_ACC: begin
          if (pop_valid) begin
            bsum <= bsum_next;
            if (bsum_ovf) begin
              clip_seen <= 1'b1;
            end
            if (ctrl.blk_end) begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          bsum <= '0;
          if (exp_raw == EXP_INF) begin
            bad_seen <= 1'b1;
          end
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          state <= S_ADD;
        end
        S_ADD: begin
          if (!row_end_q) begin
            row_sum <= row_next;
            if (row_ovf) begin
              clip_seen <= 1'b1;
            end
            state <= S_ACC;
          end else if (out_free) begin
            row_sum   <= '0;
            clip_seen <= 1'b0;
            bad_seen  <= 1'b0;
            state     <= S_ACC;
          end
        end
        default: state <= S_ACC;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_ACC && pop_valid && ctrl.blk_end) begin
      scale_q   <= ctrl.scale;
      row_end_q <= ctrl.row_end;
    end
    if (state == S_MUL) begin
      prod_q <= PROD_BITS'(mag) * PROD_BITS'(mant);
      neg_q  <= bsum[BSUM_BITS-1] ^ scale_q[15];
      exp_q  <= (exp_raw == EXP_SUBNORMAL) ? 5'd1 : exp_raw;
    end
    if (state == S_SHIFT) begin
      contrib_q <= neg_q ? -signed'(scaled) : signed'(scaled);
    end
    if (publish) begin
      dot_value <= row_next;
      saturated <= clip_seen | row_ovf;
      bad_scale <= bad_seen;
    end
  end

`ifndef SYNTHESIS
  a_block_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |=> bsum == '0)
    else $error("block sum not cleared after scaling");
  a_row_release: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADD && row_end_q && out_free) |=> (out_valid && row_sum == '0))
    else $error("row end did not publish and clear");
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_ADD)
    else $error("result raised outside row add");
`endif

endmodule
`default_nettype wire

// ----- hdl/quant_block_dot_product.sv -----
// Top level of the quantized weight-row dot product engine.
//
// Input channel (in_valid/in_ready): one transaction per weight byte with its
// activations, block scale and block/row end marks. Output channel
// (out_valid/out_ready): one transaction per finished row carrying dot_value
// (Q55.8), saturated and bad_scale.
// quant_format is written through cfg_write_en/cfg_write_data; the user must
// write it only while idle, which the block itself does not enforce:
// 0 selects four-bit blocks (two weights per byte), 1 eight-bit blocks.
// The front end decodes weights and pushes into a QUEUE_DEPTH entry queue;
// the back end drains it. The back end takes items only in its accumulate
// step; a block-ending item then runs through significand multiply,
// exponent shift and saturating row add before the next item is taken.
// At a row end the result register is loaded in the row-add step once it
// is free. If the receiver stalls, the result register holds; a following
// row end waits in the row-add step and the queue fills, then in_ready drops.
// Synchronous reset clears the format to four-bit, empties the queue and
// clears all sums and flags; no clearing pass is needed.
`default_nettype none
module quant_block_dot_product
  import qbdp_pkg::*;
#(
  parameter int ACT_BITS    = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write_en,
  input  wire logic                cfg_write_data,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire logic [7:0]          weight_byte,
  input  wire logic [ACT_BITS-1:0] act_low,
  input  wire logic [ACT_BITS-1:0] act_high,
  input  wire logic [15:0]         scale_bits,
  input  wire logic                end_of_block,
  input  wire logic                end_of_row,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      logic signed [63:0]  dot_value,
  output      logic                saturated,
  output      logic                bad_scale
);

  localparam int ENTRY_BITS = 2*ACT_BITS + $bits(item_ctrl_t);

  logic                  push_valid;
  logic                  push_ready;
  logic [ENTRY_BITS-1:0] push_data;
  logic                  pop_valid;
  logic                  pop_ready;
  logic [ENTRY_BITS-1:0] pop_data;

  // decode and format register
  qbdp_front #(
    .ACT_BITS (ACT_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .weight_byte    (weight_byte),
    .act_low        (act_low),
    .act_high       (act_high),
    .scale_bits     (scale_bits),
    .end_of_block   (end_of_block),
    .end_of_row     (end_of_row),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_data      (push_data)
  );

  // decouples the combinational front from the multi-step block-end work
  qbdp_queue #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // accumulate, scale and publish
  qbdp_back #(
    .ACT_BITS (ACT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dot_value (dot_value),
    .saturated (saturated),
    .bad_scale (bad_scale)
  );

endmodule
`default_nettype wire
